[rtl/swsc_pkg.sv]
package swsc_pkg;

    // stack geometry
    localparam int DEPTH  = 64;
    localparam int LVL_W  = $clog2(DEPTH + 1);
    localparam int CNT_W  = (DEPTH > 2) ? $clog2(DEPTH) : 1;

    localparam logic [LVL_W-1:0] LVL_FULL  = LVL_W'(DEPTH);
    localparam logic [LVL_W-1:0] LVL_EMPTY = '0;
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(DEPTH - 1);

    // field widths
    localparam int OP_W     = 3;
    localparam int WORD_W   = 32;
    localparam int SZ_W     = 7;
    localparam int STAT_W   = 2;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 56;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP   = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND  = 3'd3;
    localparam logic [OP_W-1:0] OP_COUNT = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    // word returned by pop or peek on an empty stack
    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

    // per-cell move command
    typedef enum logic [1:0] {
        SH_HOLD,
        SH_DOWN,
        SH_UP
    } shift_t;

    // chain control: move command, and whether the bottom cell takes the head
    typedef struct packed {
        shift_t cmd;
        logic   wrap;
    } chain_ctrl_t;

endpackage

[rtl/swsc_cell.sv]
module swsc_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swsc_pkg::shift_t              cmd,
    input  logic [swsc_pkg::WORD_W-1:0]   up_data,
    input  logic                          up_valid,
    input  logic [swsc_pkg::WORD_W-1:0]   dn_data,
    input  logic                          dn_valid,
    output logic [swsc_pkg::WORD_W-1:0]   data,
    output logic                          valid
);
    import swsc_pkg::*;

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic              valid_reg;
    logic              valid_next;

    // pick the neighbor to take from
    always_comb
    begin
        unique case (cmd)
            SH_DOWN:
            begin
                data_next  = up_data;
                valid_next = up_valid;
            end
            SH_UP:
            begin
                data_next  = dn_data;
                valid_next = dn_valid;
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // occupancy bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stored word
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

[rtl/swsc_chain.sv]
module swsc_chain (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swsc_pkg::chain_ctrl_t         ctrl,
    input  logic [swsc_pkg::WORD_W-1:0]   push_data,
    output logic [swsc_pkg::WORD_W-1:0]   head_data,
    output logic                          head_valid
);
    import swsc_pkg::*;

    logic [WORD_W-1:0] data_w  [DEPTH];
    logic              valid_w [DEPTH];
    logic [WORD_W-1:0] tail_data;
    logic              tail_valid;

    // bottom feed: the head word on a rotate, empty on a pop
    assign tail_data  = ctrl.wrap ? data_w[0]  : '0;
    assign tail_valid = ctrl.wrap ? valid_w[0] : 1'b0;

    // row of cells, head at index 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] up_d;
        logic              up_v;
        logic [WORD_W-1:0] dn_d;
        logic              dn_v;

        if (i == 0)
        begin : g_head
            assign up_d = push_data;
            assign up_v = 1'b1;
        end
        else
        begin : g_mid_up
            assign up_d = data_w[i-1];
            assign up_v = valid_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign dn_d = tail_data;
            assign dn_v = tail_valid;
        end
        else
        begin : g_mid_dn
            assign dn_d = data_w[i+1];
            assign dn_v = valid_w[i+1];
        end

        swsc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (ctrl.cmd),
            .up_data  (up_d),
            .up_valid (up_v),
            .dn_data  (dn_d),
            .dn_valid (dn_v),
            .data     (data_w[i]),
            .valid    (valid_w[i])
        );
    end

    assign head_data  = data_w[0];
    assign head_valid = valid_w[0];

endmodule

[rtl/stack_with_search_count.sv]
// Bounded LIFO stack of DEPTH unsigned 32-bit words held in a row of cells
// with the top of stack in the head cell. Push, pop, peek and unused
// operation codes finish without a search: the result is registered at the
// accept edge and a new item can be taken in the next cycle. Find and count
// rotate the whole row once through the head cell, whose single comparator
// checks one entry per cycle, and the row is back in place when the result
// appears. While a find or count runs, s_tready is low. A result waiting on
// m_tready holds s_tready low, so no new item is accepted until it is taken.
// No initialization pass is needed after reset.
module stack_with_search_count (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // operation[2:0], value[34:3], zero fill[39:35]
    input  logic [swsc_pkg::IN_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // data[31:0], found[32], match_count[39:33], size[46:40], status[48:47],
    // zero fill[55:49]
    output logic [swsc_pkg::OUT_W-1:0]    m_tdata
);
    import swsc_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    state_t             state_reg, state_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LVL_W-1:0]   acc_reg, acc_next;
    logic [WORD_W-1:0]  key_reg, key_next;
    logic               is_count_reg, is_count_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [WORD_W-1:0]  o_data_reg, o_data_next;
    logic               o_found_reg, o_found_next;
    logic [SZ_W-1:0]    o_match_reg, o_match_next;
    logic [SZ_W-1:0]    o_size_reg, o_size_next;
    logic [STAT_W-1:0]  o_status_reg, o_status_next;

    logic [OP_W-1:0]    operation;
    logic [WORD_W-1:0]  value;
    logic               in_fire;
    chain_ctrl_t        ctrl;
    logic [WORD_W-1:0]  head_data;
    logic               head_valid;
    logic               hit;

    assign operation = s_tdata[2:0];
    assign value     = s_tdata[34:3];
    assign s_tready  = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign in_fire   = s_tvalid && s_tready;
    assign hit       = head_valid && (head_data == key_reg);

    swsc_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .push_data  (value),
        .head_data  (head_data),
        .head_valid (head_valid)
    );

    // operation decode and search sequencing
    always_comb
    begin
        state_next    = state_reg;
        level_next    = level_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        key_next      = key_reg;
        is_count_next = is_count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        o_data_next   = o_data_reg;
        o_found_next  = o_found_reg;
        o_match_next  = o_match_reg;
        o_size_next   = o_size_reg;
        o_status_next = o_status_reg;
        ctrl.cmd      = SH_HOLD;
        ctrl.wrap     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    o_data_next   = '0;
                    o_found_next  = 1'b0;
                    o_match_next  = '0;
                    o_status_next = ST_OK;
                    m_tvalid_next = 1'b1;
                    unique case (operation)
                        OP_PUSH:
                        begin
                            if (level_reg == LVL_FULL)
                            begin
                                o_status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                ctrl.cmd   = SH_DOWN;
                                level_next = level_reg + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (level_reg == LVL_EMPTY)
                            begin
                                o_data_next   = EMPTY_WORD;
                                o_status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                ctrl.cmd    = SH_UP;
                                o_data_next = head_data;
                                level_next  = level_reg - 1'b1;
                            end
                        end
                        OP_PEEK:
                        begin
                            o_data_next = (level_reg == LVL_EMPTY) ? EMPTY_WORD : head_data;
                        end
                        OP_FIND, OP_COUNT:
                        begin
                            m_tvalid_next = 1'b0;
                            state_next    = S_SEARCH;
                            cnt_next      = '0;
                            acc_next      = '0;
                            key_next      = value;
                            is_count_next = (operation == OP_COUNT);
                        end
                        default:
                        begin
                            // unused codes give an empty result
                        end
                    endcase
                    o_size_next = SZ_W'(level_next);
                end
            end
            S_SEARCH:
            begin
                // rotate one place, checking the word now at the head
                ctrl.cmd  = SH_UP;
                ctrl.wrap = 1'b1;
                acc_next  = acc_reg + LVL_W'(hit);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                    o_data_next   = '0;
                    o_found_next  = !is_count_reg && (acc_next != LVL_EMPTY);
                    o_match_next  = is_count_reg ? SZ_W'(acc_next) : '0;
                    o_size_next   = SZ_W'(level_reg);
                    o_status_next = ST_OK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            level_reg    <= '0;
            cnt_reg      <= '0;
            acc_reg      <= '0;
            key_reg      <= '0;
            is_count_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            o_data_reg   <= '0;
            o_found_reg  <= 1'b0;
            o_match_reg  <= '0;
            o_size_reg   <= '0;
            o_status_reg <= ST_OK;
        end
        else
        begin
            state_reg    <= state_next;
            level_reg    <= level_next;
            cnt_reg      <= cnt_next;
            acc_reg      <= acc_next;
            key_reg      <= key_next;
            is_count_reg <= is_count_next;
            m_tvalid_reg <= m_tvalid_next;
            o_data_reg   <= o_data_next;
            o_found_reg  <= o_found_next;
            o_match_reg  <= o_match_next;
            o_size_reg   <= o_size_next;
            o_status_reg <= o_status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, o_status_reg, o_size_reg, o_match_reg, o_found_reg, o_data_reg};

    // a search ends with a result after the last rotation step
    a_search_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH && cnt_reg == CNT_LAST) |=> (m_tvalid && state_reg == S_IDLE))
        else $error("search did not finish with a result");

    // head cell occupancy agrees with the fill level whenever the row is at rest
    a_head_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (head_valid == (level_reg != LVL_EMPTY)))
        else $error("head cell occupancy disagrees with fill level");

    // fill level never passes the depth
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_FULL)
        else $error("fill level beyond depth");

    // a push into a stack with room grows it by one
    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && operation == OP_PUSH && level_reg != LVL_FULL)
        |=> (level_reg == $past(level_reg) + 1'b1))
        else $error("push did not grow the stack");

    // no item is taken while the row rotates
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> !s_tready)
        else $error("item accepted during search");

endmodule
